/* rtl/core/hdlcfe_pkg.sv */
package hdlcfe_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	// 0x7E ^ 0x20 = 0x5E, 0x7D ^ 0x20 = 0x5D
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] CTRL_SEQ0  = 8'h00;
	localparam logic [7:0] CTRL_SEQ1  = 8'h40;
	localparam logic [7:0] ADDR_RESET = 8'h03;

	// one classified payload byte, handed from front to back
	typedef struct packed {
		logic       open_frame;
		logic [7:0] addr;
		logic [7:0] ctrl;
		logic [7:0] data;
		logic       last;
		logic [7:0] check;
	} cmd_t;

	function automatic logic needs_escape(input logic [7:0] b);
		needs_escape = (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

endpackage

/* rtl/core/hdlcfe_if.sv */
interface hdlcfe_payload_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       sequence_req;

	modport source (output valid, output data_byte, output last_byte, output sequence_req,
		input ready);
	modport sink (input valid, input data_byte, input last_byte, input sequence_req,
		output ready);
endinterface

interface hdlcfe_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       end_of_run;
	logic       end_of_frame;

	modport source (output valid, output tx_byte, output end_of_run, output end_of_frame,
		input ready);
	modport sink (input valid, input tx_byte, input end_of_run, input end_of_frame,
		output ready);
endinterface

interface hdlcfe_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] address_byte;

	modport source (output valid, output address_byte, input ready);
	modport sink (input valid, input address_byte, output ready);
endinterface

/* rtl/core/hdlcfe_fifo.sv */
module hdlcfe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* rtl/core/hdlcfe_front.sv */
module hdlcfe_front (
	input  logic                clk,
	input  logic                arst_n,
	hdlcfe_payload_if.sink      payload,
	hdlcfe_cfg_if.sink          cfg,
	input  logic                queue_full,
	output logic                cmd_push,
	output hdlcfe_pkg::cmd_t    cmd
);
	import hdlcfe_pkg::*;

	logic [7:0] addr_q;
	logic       inside_q;
	logic [7:0] running_q;
	logic [7:0] check_next;

	assign cfg.ready     = 1'b1;
	assign payload.ready = !queue_full;
	assign cmd_push      = payload.valid && !queue_full;

	// a new frame restarts the running check
	assign check_next = (inside_q ? running_q : 8'h00) ^ payload.data_byte;

	always_comb begin
		cmd.open_frame = !inside_q;
		cmd.addr       = addr_q;
		cmd.ctrl       = payload.sequence_req ? CTRL_SEQ1 : CTRL_SEQ0;
		cmd.data       = payload.data_byte;
		cmd.last       = payload.last_byte;
		cmd.check      = check_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= ADDR_RESET;
			inside_q  <= 1'b0;
			running_q <= '0;
		end else begin
			if (cfg.valid) begin
				addr_q <= cfg.address_byte;
			end
			if (cmd_push) begin
				inside_q  <= !payload.last_byte;
				running_q <= payload.last_byte ? 8'h00 : check_next;
			end
		end
	end
endmodule

/* rtl/core/hdlcfe_back.sv */
module hdlcfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  hdlcfe_pkg::cmd_t    cmd,
	output logic                cmd_pop,
	hdlcfe_line_if.source       line
);
	import hdlcfe_pkg::*;

	typedef enum logic [3:0] {
		ST_START,
		ST_FLAG,
		ST_ADDR,
		ST_CTRL,
		ST_HCS,
		ST_DATA,
		ST_DATA_ESC,
		ST_CHK,
		ST_CHK_ESC,
		ST_CLOSE
	} step_t;

	step_t      step_q;
	step_t      cur_step;
	step_t      nxt_step;
	logic [7:0] byte_d;
	logic       eof_d;
	logic       done_d;
	logic       advance;

	logic       valid_q;
	logic [7:0] tx_q;
	logic       eor_q;
	logic       eof_q;

	assign line.valid        = valid_q;
	assign line.tx_byte      = tx_q;
	assign line.end_of_run   = eor_q;
	assign line.end_of_frame = eof_q;

	// output register takes a new byte when empty or drained this cycle
	assign advance = cmd_valid && (!valid_q || line.ready);
	assign cmd_pop = advance && done_d;

	always_comb begin
		if (step_q == ST_START) begin
			cur_step = cmd.open_frame ? ST_FLAG : ST_DATA;
		end else begin
			cur_step = step_q;
		end
	end

	always_comb begin
		byte_d   = FLAG_BYTE;
		eof_d    = 1'b0;
		done_d   = 1'b0;
		nxt_step = ST_START;
		case (cur_step)
			ST_FLAG: begin
				byte_d   = FLAG_BYTE;
				nxt_step = ST_ADDR;
			end
			ST_ADDR: begin
				byte_d   = cmd.addr;
				nxt_step = ST_CTRL;
			end
			ST_CTRL: begin
				byte_d   = cmd.ctrl;
				nxt_step = ST_HCS;
			end
			ST_HCS: begin
				byte_d   = cmd.addr ^ cmd.ctrl;
				nxt_step = ST_DATA;
			end
			ST_DATA: begin
				if (needs_escape(cmd.data)) begin
					byte_d   = ESC_BYTE;
					nxt_step = ST_DATA_ESC;
				end else begin
					byte_d   = cmd.data;
					nxt_step = cmd.last ? ST_CHK : ST_START;
					done_d   = !cmd.last;
				end
			end
			ST_DATA_ESC: begin
				byte_d   = cmd.data ^ ESC_XOR;
				nxt_step = cmd.last ? ST_CHK : ST_START;
				done_d   = !cmd.last;
			end
			ST_CHK: begin
				if (needs_escape(cmd.check)) begin
					byte_d   = ESC_BYTE;
					nxt_step = ST_CHK_ESC;
				end else begin
					byte_d   = cmd.check;
					nxt_step = ST_CLOSE;
				end
			end
			ST_CHK_ESC: begin
				byte_d   = cmd.check ^ ESC_XOR;
				nxt_step = ST_CLOSE;
			end
			ST_CLOSE: begin
				byte_d   = FLAG_BYTE;
				eof_d    = 1'b1;
				done_d   = 1'b1;
				nxt_step = ST_START;
			end
			default: begin
				byte_d   = FLAG_BYTE;
				nxt_step = ST_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_START;
			valid_q <= 1'b0;
			tx_q    <= '0;
			eor_q   <= 1'b0;
			eof_q   <= 1'b0;
		end else begin
			if (advance) begin
				step_q  <= nxt_step;
				valid_q <= 1'b1;
				tx_q    <= byte_d;
				eor_q   <= done_d;
				eof_q   <= eof_d;
			end else if (line.ready) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule

/* rtl/core/hdlc_style_frame_encoder_core.sv */
// an accepted item is written into the command queue; its first line byte is registered in
//   the output register once the item heads the queue and the output register is free
// throughput: one line byte per cycle while the line is ready, set by the back-end
//   byte sequencer; an item is 1 line byte (plain), 2 (escaped), up to 9 (frame open + close)
// a command queue of QUEUE_DEPTH entries lets the front accept while the back drains
// reset: arst_n clears the queue, frame state and output register; address resets to 0x03
module hdlc_style_frame_encoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	hdlcfe_payload_if.sink   payload,
	hdlcfe_cfg_if.sink       cfg,
	hdlcfe_line_if.source    line
);
	import hdlcfe_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_push;
	logic cmd_pop;
	logic queue_full;
	logic head_valid;

	hdlcfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload    (payload),
		.cfg        (cfg),
		.queue_full (queue_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	hdlcfe_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd_in),
		.full       (queue_full),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head_data  (cmd_head)
	);

	hdlcfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.line      (line)
	);
endmodule

/* rtl/core/hdlcfe_checker.sv */
module hdlcfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_eor,
	input logic       out_eof
);
	import hdlcfe_pkg::*;

	// closing flag always ends the run of its item
	a_eof_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eof |-> out_eor)
		else $error("end_of_frame without end_of_run");

	// closing flag carries the flag byte
	a_eof_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eof |-> out_byte == FLAG_BYTE)
		else $error("end_of_frame on a byte that is not the flag");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eor)
			&& $stable(out_eof))
		else $error("stalled line byte changed");

	// an escape byte is never the last byte of a run
	a_escape_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eor |-> out_byte != ESC_BYTE)
		else $error("run ended on an escape byte");
endmodule

bind hdlc_style_frame_encoder_core hdlcfe_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (line.valid),
	.out_ready (line.ready),
	.out_byte  (line.tx_byte),
	.out_eor   (line.end_of_run),
	.out_eof   (line.end_of_frame)
);

/* sim/testbench.sv */
module testbench;
	import hdlcfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLD_AT_ITEM   = 200;
	localparam int HOLD_CYCLES    = 100;

	typedef struct {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       sequence_req;
	} payload_item_t;

	typedef struct {
		logic [7:0] tx_byte;
		logic       end_of_run;
		logic       end_of_frame;
	} line_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	hdlcfe_payload_if payload_bus ();
	hdlcfe_cfg_if     cfg_bus ();
	hdlcfe_line_if    line_bus ();

	hdlc_style_frame_encoder_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload_bus),
		.cfg     (cfg_bus),
		.line    (line_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	payload_item_t payload_backlog[$];
	line_byte_t    line_bytes_due[$];

	// shadow of the encoder state
	logic [7:0] address_shadow = ADDR_RESET;
	logic       frame_open     = 1'b0;
	logic [7:0] payload_xor    = 8'h00;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	int mismatches    = 0;
	int items_in      = 0;
	int frames_closed = 0;
	int bytes_checked = 0;
	int escapes_due   = 0;
	int address_writes = 0;

	task automatic add_line(input logic [7:0] b, input logic eof, input logic eor);
		line_bytes_due.push_back('{tx_byte: b, end_of_run: eor, end_of_frame: eof});
	endtask

	// eor marks the last line byte of this item's run
	task automatic add_stuffed(input logic [7:0] b, input logic eor);
		if (b == FLAG_BYTE || b == ESC_BYTE) begin
			escapes_due++;
			add_line(ESC_BYTE, 1'b0, 1'b0);
			add_line(b ^ ESC_XOR, 1'b0, eor);
		end else begin
			add_line(b, 1'b0, eor);
		end
	endtask

	task automatic encode_payload_byte(input logic [7:0] d, input logic l, input logic s);
		logic [7:0] ctrl;
		if (!frame_open) begin
			ctrl = s ? CTRL_SEQ1 : CTRL_SEQ0;
			add_line(FLAG_BYTE, 1'b0, 1'b0);
			add_line(address_shadow, 1'b0, 1'b0);
			add_line(ctrl, 1'b0, 1'b0);
			add_line(address_shadow ^ ctrl, 1'b0, 1'b0);
			frame_open  = 1'b1;
			payload_xor = 8'h00;
		end
		payload_xor = payload_xor ^ d;
		if (l) begin
			add_stuffed(d, 1'b0);
			add_stuffed(payload_xor, 1'b0);
			add_line(FLAG_BYTE, 1'b1, 1'b1);
			frame_open  = 1'b0;
			payload_xor = 8'h00;
			frames_closed++;
		end else begin
			add_stuffed(d, 1'b1);
		end
	endtask

	// payload driver
	payload_item_t next_item;
	always @(posedge clk) begin
		if (!arst_n) begin
			payload_bus.valid <= 1'b0;
		end else if (!payload_bus.valid || payload_bus.ready) begin
			if (payload_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_item = payload_backlog.pop_front();
				payload_bus.valid        <= 1'b1;
				payload_bus.data_byte    <= next_item.data_byte;
				payload_bus.last_byte    <= next_item.last_byte;
				payload_bus.sequence_req <= next_item.sequence_req;
			end else begin
				payload_bus.valid <= 1'b0;
			end
		end
	end

	// line receiver, with one long hold-off once the run is well under way
	int rx_items_seen = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	always @(posedge clk) begin
		if (arst_n && payload_bus.valid && payload_bus.ready)
			rx_items_seen++;
		if (!hold_done && rx_items_seen >= HOLD_AT_ITEM) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			line_bus.ready <= 1'b0;
		end else begin
			line_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: predicts on payload transfers, checks line transfers
	line_byte_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				address_shadow = cfg_bus.address_byte;
				address_writes++;
			end
			if (payload_bus.valid && payload_bus.ready) begin
				encode_payload_byte(payload_bus.data_byte, payload_bus.last_byte,
					payload_bus.sequence_req);
				items_in++;
			end
			if (line_bus.valid && line_bus.ready) begin
				if (line_bytes_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected line byte %h (eor %b eof %b), nothing pending",
							line_bus.tx_byte, line_bus.end_of_run, line_bus.end_of_frame);
					mismatches++;
				end else begin
					want = line_bytes_due.pop_front();
					if (line_bus.tx_byte !== want.tx_byte
							|| line_bus.end_of_run !== want.end_of_run
							|| line_bus.end_of_frame !== want.end_of_frame) begin
						if (mismatches < 10)
							$display("line byte %0d: expected %h eor %b eof %b, got %h eor %b eof %b",
								bytes_checked, want.tx_byte, want.end_of_run, want.end_of_frame,
								line_bus.tx_byte, line_bus.end_of_run, line_bus.end_of_frame);
						mismatches++;
					end
				end
				bytes_checked++;
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((payload_bus.valid && payload_bus.ready) || (line_bus.valid && line_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d line bytes pending",
					quiet_cycles, line_bytes_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic [7:0] d, input logic l, input logic s);
		payload_backlog.push_back('{data_byte: d, last_byte: l, sequence_req: s});
	endtask

	// sender pauses until every predicted byte is out
	task automatic drain();
		do @(posedge clk);
		while (payload_backlog.size() != 0 || payload_bus.valid || line_bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] a);
		@(posedge clk);
		cfg_bus.valid        <= 1'b1;
		cfg_bus.address_byte <= a;
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic random_frames(input int n_items, input int tx_pct, input int rx_pct,
			input logic [7:0] a);
		int made;
		int len;
		logic [7:0] d;
		made = 0;
		drain();
		write_address(a);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (made < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(7))
					0: d = FLAG_BYTE;
					1: d = ESC_BYTE;
					default: d = 8'($urandom_range(255));
				endcase
				queue_item(d, i == len - 1, 1'($urandom_range(1)));
			end
			made += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		payload_bus.valid        = 1'b0;
		payload_bus.data_byte    = 8'h00;
		payload_bus.last_byte    = 1'b0;
		payload_bus.sequence_req = 1'b0;
		cfg_bus.valid            = 1'b0;
		cfg_bus.address_byte     = 8'h00;
		line_bus.ready           = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// single-byte frames at the reset address, both sequence values
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b1);
		// escaped byte and escaped check in one run
		queue_item(FLAG_BYTE, 1'b1, 1'b0);
		queue_item(ESC_BYTE, 1'b1, 1'b1);
		// sequence bit flips mid-frame must be ignored
		queue_item(FLAG_BYTE, 1'b0, 1'b1);
		queue_item(ESC_BYTE, 1'b0, 1'b0);
		queue_item(8'h01, 1'b0, 1'b1);
		queue_item(8'h03, 1'b1, 1'b0);
		// data check lands on 0x7e, then on 0x7d
		queue_item(8'h70, 1'b0, 1'b0);
		queue_item(8'h0E, 1'b1, 1'b0);
		queue_item(8'h70, 1'b0, 1'b1);
		queue_item(8'h0D, 1'b1, 1'b1);
		// address change with a frame open only shows up in the next header
		queue_item(8'h55, 1'b0, 1'b0);
		drain();
		write_address(FLAG_BYTE);
		queue_item(8'hAA, 1'b1, 1'b1);
		// header bytes equal to flag go out unstuffed
		queue_item(8'h11, 1'b1, 1'b0);
		queue_item(8'h22, 1'b1, 1'b1);
		drain();
		// header check equal to escape
		write_address(8'h3D);
		queue_item(8'h33, 1'b1, 1'b1);
		drain();
		write_address(ESC_BYTE);
		queue_item(8'h44, 1'b1, 1'b0);

		random_frames(70, 32, 54, 8'h00);
		random_frames(70, 54, 32, 8'hFF);
		random_frames(72, 0, 0, 8'($urandom_range(255)));
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d payload bytes in %0d frames, %0d line bytes, %0d escapes",
			items_in, frames_closed, bytes_checked, escapes_due);
		$display("over %0d address writes, one long line stall, %0d mismatches",
			address_writes, mismatches);
		if (mismatches == 0 && line_bytes_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
